// File: rtl/core/todc_pkg.sv
// todc_pkg: command codes, pipeline payload types and constants
// for the time-of-day counter core; no dependencies
package todc_pkg;

  localparam int unsigned HOUR_SECONDS   = 3600;
  localparam int unsigned MINUTE_SECONDS = 60;
  localparam int unsigned HOURS_PER_DAY  = 24;
  localparam int unsigned MAX_MINUTE     = 59;
  localparam int unsigned MAX_HOUR       = 23;
  localparam int signed   DIFF_LIMIT     = 86399;

  // 86400 = 128 * 675; 2^12 mod 675 = 46; 280 * 675 keeps the fold positive
  localparam int unsigned MOD_BASE       = 675;
  localparam int unsigned FOLD_WEIGHT    = 46;
  localparam int unsigned FOLD_OFFSET    = 189000;

  // reciprocal multipliers, each rounded down
  localparam int unsigned RECIP_675      = 97;    // 2^16 / 675
  localparam int unsigned RECIP_225      = 1165;  // 2^18 / 225
  localparam int unsigned RECIP_15       = 4369;  // 2^16 / 15

  typedef enum logic [2:0] {
    CMD_TICK_UP  = 3'd0,
    CMD_TICK_DN  = 3'd1,
    CMD_SET      = 3'd2,
    CMD_NORM_SET = 3'd3,
    CMD_SHIFT    = 3'd4,
    CMD_DIFF     = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] hours;
    logic [15:0] minutes;
    logic [15:0] seconds;
    logic [31:0] shift;
  } in_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        set_ok;
    logic [4:0]  set_h;
    logic [5:0]  set_m;
    logic [5:0]  set_s;
    logic [27:0] given;
    logic [31:0] tval;
    logic [18:0] vfold;
    logic [6:0]  lo7;
    logic [13:0] wfold;
    logic [3:0]  q675;
    logic [16:0] tmod;
    logic [4:0]  hq;
    logic [11:0] rem;
    logic [5:0]  mq;
    logic [4:0]  dh;
    logic [5:0]  dm;
    logic [5:0]  ds;
  } pipe_t;

endpackage

// File: rtl/core/time_of_day_counter_core.sv
// time_of_day_counter_core: hh:mm:ss time-of-day counter with tick, set,
// shift and difference commands; depends on todc_pkg
//
// usage:
//   input channel in_*: one command per transfer (cmd, hours/minutes/seconds,
//   shift amount). result channel out_*: one result per command with the
//   time after the command, the strict-set error flag and the difference.
//   a result reaches the output register through the input register and
//   each payload stage. throughput: one command per cycle while out_stall is low.
//   the pipeline depth comes from the chain that reduces a signed total modulo one
//   day and splits it into hours, minutes and seconds (fold, reciprocal
//   multiply and correct, one step per stage); none of it depends on the
//   stored time. the stored time is read and written only in the last stage,
//   a single-cycle loop, so back-to-back commands see each other's effect.
//   reset (rst_n low, synchronous) sets the time to 00:00:00 and empties the
//   pipeline. when the receiver stalls, the output register holds its result,
//   bubbles in the pipeline are squeezed out, and in_stall rises only once
//   every stage is full.
module time_of_day_counter_core
  import todc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_hours_in,
  input  logic [15:0] in_minutes_in,
  input  logic [15:0] in_seconds_in,
  input  logic [31:0] in_shift_amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_hours_out,
  output logic [5:0]  out_minutes_out,
  output logic [5:0]  out_seconds_out,
  output logic        out_invalid_time,
  output logic [17:0] out_diff_seconds
);

  localparam int NST = 11;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] rdy;
  in_t            in_r;
  pipe_t          st_r   [1:NST-2];
  pipe_t          st_nxt [1:NST-2];

  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic        invalid_nxt;
  logic [17:0] diff_nxt;
  logic [4:0]  out_h_r;
  logic [5:0]  out_m_r;
  logic [5:0]  out_s_r;
  logic        out_inv_r;
  logic [17:0] out_diff_r;
  logic        load_final;

  // ready chain, last stage first
  always_comb begin
    rdy[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall   = !rdy[0];
  assign load_final = rdy[NST-1] && vld_r[NST-2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // state-independent stages
  always_comb begin
    logic signed [27:0] giv;
    logic signed [31:0] tv;
    logic signed [24:0] q;
    logic signed [19:0] vs;
    logic [13:0]        r0;
    logic [16:0]        h0;
    logic [11:0]        s0;

    // stage 1: range check, signed total, operand select
    st_nxt[1]        = '0;
    st_nxt[1].cmd    = in_r.cmd;
    st_nxt[1].set_ok = ($signed(in_r.hours) >= 16'sd0)
                    && ($signed(in_r.hours) <= 16'(MAX_HOUR))
                    && ($signed(in_r.minutes) >= 16'sd0)
                    && ($signed(in_r.minutes) <= 16'(MAX_MINUTE))
                    && ($signed(in_r.seconds) >= 16'sd0)
                    && ($signed(in_r.seconds) <= 16'(MAX_MINUTE));
    st_nxt[1].set_h  = in_r.hours[4:0];
    st_nxt[1].set_m  = in_r.minutes[5:0];
    st_nxt[1].set_s  = in_r.seconds[5:0];
    giv = 28'($signed(in_r.hours)) * 28'(HOUR_SECONDS)
        + 28'($signed(in_r.minutes)) * 28'(MINUTE_SECONDS)
        + 28'($signed(in_r.seconds));
    st_nxt[1].given  = giv;
    st_nxt[1].tval   = (in_r.cmd == CMD_NORM_SET) ? 32'(giv) : in_r.shift;

    // stage 2: split off 7 low bits, fold upper part mod 675
    st_nxt[2]       = st_r[1];
    tv              = $signed(st_r[1].tval);
    q               = 25'(tv >>> 7);
    vs              = 20'($signed(q[24:12])) * 20'(FOLD_WEIGHT)
                    + 20'({8'b0, q[11:0]}) + 20'(FOLD_OFFSET);
    st_nxt[2].vfold = vs[18:0];
    st_nxt[2].lo7   = st_r[1].tval[6:0];

    // stage 3: second fold
    st_nxt[3]       = st_r[2];
    st_nxt[3].wfold = 14'(st_r[2].vfold[18:12]) * 14'(FOLD_WEIGHT)
                    + 14'(st_r[2].vfold[11:0]);

    // stage 4: quotient estimate by 675
    st_nxt[4]      = st_r[3];
    st_nxt[4].q675 = 4'((22'(st_r[3].wfold) * 22'(RECIP_675)) >> 16);

    // stage 5: remainder with one correction, rebuild value mod one day
    st_nxt[5]      = st_r[4];
    r0             = st_r[4].wfold - 14'(st_r[4].q675) * 14'(MOD_BASE);
    if (r0 >= 14'(MOD_BASE)) begin
      r0 = r0 - 14'(MOD_BASE);
    end
    st_nxt[5].tmod = {r0[9:0], st_r[4].lo7};

    // stage 6: hour estimate
    st_nxt[6]    = st_r[5];
    st_nxt[6].hq = 5'((24'(st_r[5].tmod[16:4]) * 24'(RECIP_225)) >> 18);

    // stage 7: hour correction, seconds within the hour
    st_nxt[7] = st_r[6];
    h0        = st_r[6].tmod - 17'(st_r[6].hq) * 17'(HOUR_SECONDS);
    if (h0 >= 17'(HOUR_SECONDS)) begin
      h0           = h0 - 17'(HOUR_SECONDS);
      st_nxt[7].hq = st_r[6].hq + 5'd1;
    end
    st_nxt[7].rem = h0[11:0];

    // stage 8: minute estimate
    st_nxt[8]    = st_r[7];
    st_nxt[8].mq = 6'((23'(st_r[7].rem[11:2]) * 23'(RECIP_15)) >> 16);

    // stage 9: minute correction, hms delta
    st_nxt[9]    = st_r[8];
    st_nxt[9].dh = st_r[8].hq;
    st_nxt[9].dm = st_r[8].mq;
    s0           = st_r[8].rem - 12'(st_r[8].mq) * 12'(MINUTE_SECONDS);
    if (s0 >= 12'(MINUTE_SECONDS)) begin
      s0           = s0 - 12'(MINUTE_SECONDS);
      st_nxt[9].dm = st_r[8].mq + 6'd1;
    end
    st_nxt[9].ds = s0[5:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      in_r <= '{cmd: cmd_t'(in_cmd), hours: in_hours_in, minutes: in_minutes_in,
                seconds: in_seconds_in, shift: in_shift_amount};
    end
    for (int k = 1; k <= NST - 2; k++) begin
      if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // last stage: time update and result
  always_comb begin
    logic [6:0]         ssum;
    logic [6:0]         msum;
    logic [5:0]         hsum;
    logic               c0;
    logic               c1;
    logic [16:0]        now;
    logic signed [28:0] dfull;

    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    second_nxt  = second_r;
    invalid_nxt = 1'b0;
    diff_nxt    = '0;
    ssum        = 7'(second_r) + 7'(st_r[NST-2].ds);
    c0          = ssum >= 7'(MINUTE_SECONDS);
    msum        = 7'(minute_r) + 7'(st_r[NST-2].dm) + 7'(c0);
    c1          = msum >= 7'(MINUTE_SECONDS);
    hsum        = 6'(hour_r) + 6'(st_r[NST-2].dh) + 6'(c1);
    now         = 17'(hour_r) * 17'(HOUR_SECONDS) + 17'(minute_r) * 17'(MINUTE_SECONDS)
                + 17'(second_r);
    dfull       = 29'($signed({1'b0, now})) - 29'($signed(st_r[NST-2].given));
    case (st_r[NST-2].cmd)
      CMD_TICK_UP: begin
        if (second_r < 6'(MAX_MINUTE)) begin
          second_nxt = second_r + 6'd1;
        end else begin
          second_nxt = '0;
          if (minute_r < 6'(MAX_MINUTE)) begin
            minute_nxt = minute_r + 6'd1;
          end else begin
            minute_nxt = '0;
            hour_nxt   = (hour_r < 5'(MAX_HOUR)) ? hour_r + 5'd1 : '0;
          end
        end
      end
      CMD_TICK_DN: begin
        if (second_r != '0) begin
          second_nxt = second_r - 6'd1;
        end else begin
          second_nxt = 6'(MAX_MINUTE);
          if (minute_r != '0) begin
            minute_nxt = minute_r - 6'd1;
          end else begin
            minute_nxt = 6'(MAX_MINUTE);
            hour_nxt   = (hour_r != '0) ? hour_r - 5'd1 : 5'(MAX_HOUR);
          end
        end
      end
      CMD_SET: begin
        if (st_r[NST-2].set_ok) begin
          hour_nxt   = st_r[NST-2].set_h;
          minute_nxt = st_r[NST-2].set_m;
          second_nxt = st_r[NST-2].set_s;
        end else begin
          invalid_nxt = 1'b1;
        end
      end
      CMD_NORM_SET: begin
        hour_nxt   = st_r[NST-2].dh;
        minute_nxt = st_r[NST-2].dm;
        second_nxt = st_r[NST-2].ds;
      end
      CMD_SHIFT: begin
        second_nxt = c0 ? 6'(ssum - 7'(MINUTE_SECONDS)) : ssum[5:0];
        minute_nxt = c1 ? 6'(msum - 7'(MINUTE_SECONDS)) : msum[5:0];
        hour_nxt   = (hsum >= 6'(HOURS_PER_DAY)) ? 5'(hsum - 6'(HOURS_PER_DAY)) : hsum[4:0];
      end
      CMD_DIFF: begin
        if (dfull > 29'(DIFF_LIMIT)) begin
          diff_nxt = 18'(DIFF_LIMIT);
        end else if (dfull < -29'(DIFF_LIMIT)) begin
          diff_nxt = -18'(DIFF_LIMIT);
        end else begin
          diff_nxt = dfull[17:0];
        end
      end
      default: begin
        diff_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
    end else if (load_final) begin
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      out_h_r    <= hour_nxt;
      out_m_r    <= minute_nxt;
      out_s_r    <= second_nxt;
      out_inv_r  <= invalid_nxt;
      out_diff_r <= diff_nxt;
    end
  end

  assign out_valid        = vld_r[NST-1];
  assign out_hours_out    = out_h_r;
  assign out_minutes_out  = out_m_r;
  assign out_seconds_out  = out_s_r;
  assign out_invalid_time = out_inv_r;
  assign out_diff_seconds = out_diff_r;

  // stored time stays a legal time of day
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    hour_r <= 5'(MAX_HOUR) && minute_r <= 6'(MAX_MINUTE) && second_r <= 6'(MAX_MINUTE))
    else $error("stored time out of range");

  // time changes only when a result enters the output register
  a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !load_final) |=> ($stable(hour_r) && $stable(minute_r) && $stable(second_r)))
    else $error("time changed without a result");

  // difference saturates to one day less a second
  a_diff_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_diff_seconds) <= 18'(DIFF_LIMIT)
                && $signed(out_diff_seconds) >= -18'(DIFF_LIMIT)))
    else $error("difference out of range");

  // a rejected set carries no difference
  a_inv_nodiff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid_time) |-> (out_diff_seconds == '0))
    else $error("rejected set with nonzero difference");

  // input stalls only when the first stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> vld_r[0])
    else $error("input stalled with empty first stage");

endmodule
